FILE: hw/rtl/dbf_pkg.sv
// Shared types, constants and the bond length table for the distance bond finder.
`default_nettype none
package dbf_pkg;

  // Storage and field widths
  localparam int MAX_ATOMS   = 1024;
  localparam int IDX_W       = $clog2(MAX_ATOMS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAX_VALENCE = 8;
  localparam int VAL_W       = 4;
  localparam int POS_W       = 24;
  localparam int KIND_W      = 3;
  localparam int NUM_KINDS   = 8;
  localparam int BOX_W       = 23;
  localparam int SCALE_W     = 16;
  localparam int LEN_W       = 10;
  localparam int DR_W        = POS_W + 2;
  localparam int T_W         = LEN_W + SCALE_W;
  localparam int D2_W        = 52;
  localparam int REF_W       = 10;
  localparam int LIM_SHIFT   = 24;
  localparam int LIM_W       = D2_W + 1 - LIM_SHIFT;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [REF_W-1:0] REF_MAX    = {REF_W{1'b1}};
  localparam logic [D2_W:0]    LIM_ROUND  = (D2_W + 1)'((64'd1 << LIM_SHIFT) - 64'd1);
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4915;

  // Result item kinds
  localparam logic ITEM_BOND    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PERIODIC = 3'd0;
  localparam logic [2:0] REG_BOX_X    = 3'd1;
  localparam logic [2:0] REG_BOX_Y    = 3'd2;
  localparam logic [2:0] REG_BOX_Z    = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;

  // Bond lengths per kind pair, 1/256 angstrom (order ? N C O S H P F)
  localparam logic [LEN_W-1:0] LEN_TABLE [NUM_KINDS][NUM_KINDS] = '{
    '{10'd794, 10'd538, 10'd538, 10'd563, 10'd589, 10'd384, 10'd589, 10'd435},
    '{10'd538, 10'd376, 10'd387, 10'd380, 10'd445, 10'd266, 10'd423, 10'd346},
    '{10'd538, 10'd387, 10'd394, 10'd346, 10'd466, 10'd279, 10'd476, 10'd353},
    '{10'd563, 10'd380, 10'd346, 10'd362, 10'd402, 10'd247, 10'd404, 10'd371},
    '{10'd589, 10'd445, 10'd466, 10'd402, 10'd522, 10'd346, 10'd535, 10'd435},
    '{10'd384, 10'd266, 10'd279, 10'd247, 10'd346, 10'd192, 10'd376, 10'd236},
    '{10'd589, 10'd423, 10'd476, 10'd404, 10'd535, 10'd376, 10'd566, 10'd333},
    '{10'd435, 10'd346, 10'd353, 10'd371, 10'd435, 10'd236, 10'd333, 10'd361}
  };

  typedef struct packed {
    logic               periodic_mode;
    logic [BOX_W-1:0]   box_x;
    logic [BOX_W-1:0]   box_y;
    logic [BOX_W-1:0]   box_z;
    logic [SCALE_W-1:0] bond_scale;
  } cfg_t;

  // One classified atom waiting for the pair sweep
  typedef struct packed {
    logic                    overflow;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [KIND_W-1:0]       kind;
  } job_t;

  typedef struct packed {
    logic              item_kind;
    logic [IDX_W-1:0]  new_index;
    logic [IDX_W-1:0]  partner_index;
    logic [D2_W-1:0]   dist_squared;
    logic [VAL_W-1:0]  neighbour_count;
    logic [REF_W-1:0]  refused_count;
    logic              overflow;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dbf_front.sv
// Front end: accepts atom requests, tracks the atom count and builds pair-sweep jobs.
`default_nettype none
module dbf_front import dbf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    first_atom,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic [KIND_W-1:0]       atom_kind,
  input  wire logic                    q_full,
  output logic                         q_push,
  output job_t                         q_job
);

  logic [CNT_W-1:0] atom_count;
  logic [CNT_W-1:0] base;
  logic             ovf;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Pick the index of this atom; a start flag restarts the set
  always_comb begin
    base = first_atom ? '0 : atom_count;
    ovf  = (base >= CNT_W'(MAX_ATOMS));
    q_job.overflow = ovf;
    q_job.idx      = base[IDX_W-1:0];
    q_job.pos_x    = pos_x;
    q_job.pos_y    = pos_y;
    q_job.pos_z    = pos_z;
    q_job.kind     = atom_kind;
  end

  // Advance the count unless the store is full
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= '0;
    end else if (q_push) begin
      atom_count <= ovf ? base : base + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dbf_queue.sv
// Short job queue between the front end and the pair sweep.
`default_nettype none
module dbf_queue import dbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dbf_back.sv
// Back end: atom store, pipelined pair sweep, valence bookkeeping and result register.
`default_nettype none
module dbf_back import dbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_ready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t state;
  job_t   cur;

  logic [IDX_W-1:0] j;
  logic [VAL_W-1:0] val_new;
  logic [REF_W-1:0] refused;

  // Atom store
  logic signed [POS_W-1:0] x_mem [MAX_ATOMS];
  logic signed [POS_W-1:0] y_mem [MAX_ATOMS];
  logic signed [POS_W-1:0] z_mem [MAX_ATOMS];
  logic [KIND_W-1:0]       k_mem [MAX_ATOMS];
  logic [VAL_W-1:0]        v_mem [MAX_ATOMS];

  // Stage 1: store read
  logic                    v1;
  logic [IDX_W-1:0]        j1;
  logic signed [POS_W-1:0] rd_x, rd_y, rd_z;
  logic [KIND_W-1:0]       rd_kind;
  logic [VAL_W-1:0]        rd_val;
  // Stage 2: differences and threshold
  logic                    v2;
  logic [IDX_W-1:0]        j2;
  logic [VAL_W-1:0]        val2;
  logic signed [DR_W-1:0]  dx2, dy2, dz2;
  logic [T_W-1:0]          t2;
  // Stage 3: minimum image and threshold square
  logic                    v3;
  logic [IDX_W-1:0]        j3;
  logic [VAL_W-1:0]        val3;
  logic signed [DR_W-1:0]  wx3, wy3, wz3;
  logic [D2_W-1:0]         tt3;
  // Stage 4: axis squares and rounded limit
  logic                    v4;
  logic [IDX_W-1:0]        j4;
  logic [VAL_W-1:0]        val4;
  logic [D2_W-1:0]         sqx4, sqy4, sqz4;
  logic [LIM_W-1:0]        lim4;
  // Stage 5: squared distance, decision
  logic                    v5;
  logic [IDX_W-1:0]        j5;
  logic [VAL_W-1:0]        val5;
  logic [D2_W-1:0]         d2_5;
  logic [LIM_W-1:0]        lim5;

  logic          v0, adv, out_free, hit, full_val, bond, sum_take, run_done, pos_we;
  logic [D2_W:0] tt_round;

  function automatic logic signed [DR_W-1:0] min_image(
    input logic signed [DR_W-1:0] d,
    input logic [BOX_W-1:0]       box,
    input logic                   en
  );
    logic signed [DR_W:0]   d_twice;
    logic signed [DR_W:0]   box_w;
    logic signed [DR_W-1:0] box_s;
    d_twice = {d, 1'b0};
    box_w   = signed'({(DR_W + 1 - BOX_W)'(0), box});
    box_s   = signed'({(DR_W - BOX_W)'(0), box});
    if (en && (d_twice > box_w)) begin
      return d - box_s;
    end else if (en && (d_twice < -box_w)) begin
      return d + box_s;
    end else begin
      return d;
    end
  endfunction

  assign out_free = !res_valid || res_ready;
  assign v0       = (state == ST_RUN) && (j != cur.idx);
  assign hit      = v5 && (d2_5 < D2_W'(lim5));
  assign full_val = (val_new >= VAL_W'(MAX_VALENCE)) || (val5 >= VAL_W'(MAX_VALENCE));
  assign bond     = hit && !full_val;
  assign adv      = !(bond && !out_free);
  assign run_done = (state == ST_RUN) && (j == cur.idx) && !(v1 || v2 || v3 || v4 || v5);
  assign sum_take = (state == ST_SUM) && out_free;
  assign q_pop    = sum_take;
  assign pos_we   = (state == ST_IDLE) && q_valid && !q_job.overflow;
  assign tt_round = {1'b0, tt3} + LIM_ROUND;

  // Write new atoms, read partners, update valences
  always_ff @(posedge clk) begin
    if (pos_we) begin
      x_mem[q_job.idx] <= q_job.pos_x;
      y_mem[q_job.idx] <= q_job.pos_y;
      z_mem[q_job.idx] <= q_job.pos_z;
      k_mem[q_job.idx] <= q_job.kind;
    end
    if (adv) begin
      rd_x    <= x_mem[j];
      rd_y    <= y_mem[j];
      rd_z    <= z_mem[j];
      rd_kind <= k_mem[j];
      rd_val  <= v_mem[j];
    end
    if (adv && bond) begin
      v_mem[j5] <= val5 + VAL_W'(1);
    end else if (sum_take && !cur.overflow) begin
      v_mem[cur.idx] <= val_new;
    end
  end

  // Pair pipeline datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      j1   <= j;
      j2   <= j1;
      val2 <= rd_val;
      dx2  <= DR_W'(cur.pos_x) - DR_W'(rd_x);
      dy2  <= DR_W'(cur.pos_y) - DR_W'(rd_y);
      dz2  <= DR_W'(cur.pos_z) - DR_W'(rd_z);
      t2   <= LEN_TABLE[cur.kind][rd_kind] * cfg.bond_scale;
      j3   <= j2;
      val3 <= val2;
      wx3  <= min_image(dx2, cfg.box_x, cfg.periodic_mode);
      wy3  <= min_image(dy2, cfg.box_y, cfg.periodic_mode);
      wz3  <= min_image(dz2, cfg.box_z, cfg.periodic_mode);
      tt3  <= t2 * t2;
      j4   <= j3;
      val4 <= val3;
      sqx4 <= wx3 * wx3;
      sqy4 <= wy3 * wy3;
      sqz4 <= wz3 * wz3;
      lim4 <= tt_round[D2_W:LIM_SHIFT];
      j5   <= j4;
      val5 <= val4;
      d2_5 <= sqx4 + sqy4 + sqz4;
      lim5 <= lim4;
    end
  end

  // Sequence jobs, stage valids, counts and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      j         <= '0;
      val_new   <= '0;
      refused   <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Hold a result until it is taken
      if ((adv && bond) || sum_take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (adv) begin
        v1 <= v0;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
        v5 <= v4;
        if (v0) begin
          j <= j + IDX_W'(1);
        end
        if (bond) begin
          val_new                 <= val_new + VAL_W'(1);
          res.item_kind           <= ITEM_BOND;
          res.new_index           <= cur.idx;
          res.partner_index       <= j5;
          res.dist_squared        <= d2_5;
          res.neighbour_count     <= val_new + VAL_W'(1);
          res.refused_count       <= refused;
          res.overflow            <= 1'b0;
          res.last                <= 1'b0;
        end else if (hit && (refused != REF_MAX)) begin
          refused <= refused + REF_W'(1);
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur     <= q_job;
            j       <= '0;
            val_new <= '0;
            refused <= '0;
            state   <= q_job.overflow ? ST_SUM : ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_done) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (sum_take) begin
            res.item_kind       <= ITEM_SUMMARY;
            res.new_index       <= cur.idx;
            res.partner_index   <= '0;
            res.dist_squared    <= '0;
            res.neighbour_count <= val_new;
            res.refused_count   <= refused;
            res.overflow        <= cur.overflow;
            res.last            <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/distance_bond_finder.sv
// Top level: configuration registers, front end, job queue and pair sweep.
`default_nettype none
// Distance bond finder. Each atom request enters a two-job queue; the sweep
// then compares it with every stored earlier atom at one pair per cycle
// through a five-stage pipeline, and stalls for as long as a bond result
// waits on the downstream side. The store read in the sweep sets that rate.
// Bonds come out in partner index order, each atom's run closed by a summary
// with last set. No clearing pass is needed after reset. Registers (APB, byte
// address 4*i): periodic_mode, box_x, box_y, box_z, bond_scale (reset 4915);
// write them only while no atom is in flight.
module distance_bond_finder import dbf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [4:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    first_atom,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic [KIND_W-1:0]       atom_kind,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         item_kind,
  output logic [IDX_W-1:0]             new_index,
  output logic [IDX_W-1:0]             partner_index,
  output logic [D2_W-1:0]              dist_squared,
  output logic [VAL_W-1:0]             neighbour_count,
  output logic [REF_W-1:0]             refused_count,
  output logic                         overflow,
  output logic                         last
);

  cfg_t       cfg;
  logic [2:0] reg_sel;
  logic       cfg_we;
  logic       q_full, q_push, q_pop, q_valid;
  job_t       push_job, head_job;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.periodic_mode <= 1'b0;
      cfg.box_x         <= '0;
      cfg.box_y         <= '0;
      cfg.box_z         <= '0;
      cfg.bond_scale    <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_PERIODIC: cfg.periodic_mode <= pwdata[0];
        REG_BOX_X:    cfg.box_x         <= pwdata[BOX_W-1:0];
        REG_BOX_Y:    cfg.box_y         <= pwdata[BOX_W-1:0];
        REG_BOX_Z:    cfg.box_z         <= pwdata[BOX_W-1:0];
        REG_SCALE:    cfg.bond_scale    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_PERIODIC: prdata = {31'd0, cfg.periodic_mode};
      REG_BOX_X:    prdata = 32'(cfg.box_x);
      REG_BOX_Y:    prdata = 32'(cfg.box_y);
      REG_BOX_Z:    prdata = 32'(cfg.box_z);
      REG_SCALE:    prdata = 32'(cfg.bond_scale);
      default:      prdata = '0;
    endcase
  end

  dbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .first_atom (first_atom),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .atom_kind  (atom_kind),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  dbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  dbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res),
    .res_ready (out_ready)
  );

  assign item_kind       = res.item_kind;
  assign new_index       = res.new_index;
  assign partner_index   = res.partner_index;
  assign dist_squared    = res.dist_squared;
  assign neighbour_count = res.neighbour_count;
  assign refused_count   = res.refused_count;
  assign overflow        = res.overflow;
  assign last            = res.last;

endmodule
`default_nettype wire
